FILE: rtl/ssmva_pkg.sv
package ssmva_pkg;

  localparam int unsigned VOXELS_DEF = 1024;
  localparam int unsigned SAMPLES_DEF = 64;
  localparam int unsigned DIRECTIONS_DEF = 512;
  localparam int unsigned MAX_COMP_DEF = 4;
  localparam int unsigned LANES = 4;

  localparam int unsigned VOX_W = 10;
  localparam int unsigned ORI_W = 9;
  localparam int unsigned SMP_W = 6;
  localparam int unsigned CMP_W = 2;
  localparam int unsigned LEN_W = 31;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ACC_W = 48;
  localparam int unsigned TERM_W = 42;
  localparam int unsigned DOT_W = 44;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_INTRA = 3'd0,
    OP_EXTRA = 3'd1,
    OP_ISO = 3'd2,
    OP_LD_INTRA = 3'd3,
    OP_LD_EXTRA = 3'd4,
    OP_LD_ISO = 3'd5,
    OP_READ = 3'd6,
    OP_CLEAR = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    REG_NUM_RADII = 2'd0,
    REG_NUM_EXTRA = 2'd1,
    REG_NUM_ISO = 2'd2,
    REG_NUM_SAMPLES = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_CLEAR
  } state_t;

  // lane control handed to the lane array each sweep cycle
  typedef struct packed {
    logic       valid;
    logic       is_intra;
    logic [3:0] lane_en;
  } lane_ctl_t;

endpackage

FILE: rtl/ssmva_lane.sv
// one compartment lane: kernel memory plus coefficient product floored to Q.24
module ssmva_lane #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned ISO_DEPTH = 64,
  parameter int unsigned AW = 15,
  parameter int unsigned IAW = 6
) (
  input  logic                              clk,
  input  logic                              wr_intra,
  input  logic                              wr_extra,
  input  logic                              wr_iso,
  input  logic [AW-1:0]                     wr_addr,
  input  logic [IAW-1:0]                    wr_iso_addr,
  input  logic signed [ssmva_pkg::WORD_W-1:0] wr_data,
  input  logic [AW-1:0]                     rd_addr,
  input  logic [IAW-1:0]                    rd_iso_addr,
  input  logic [1:0]                        rd_sel,
  input  logic                              en,
  input  logic signed [ssmva_pkg::WORD_W-1:0] coef,
  output logic signed [ssmva_pkg::TERM_W-1:0] term
);
  import ssmva_pkg::*;

  logic signed [WORD_W-1:0] intra_mem [DEPTH];
  logic signed [WORD_W-1:0] extra_mem [DEPTH];
  logic signed [WORD_W-1:0] iso_mem [ISO_DEPTH];
  logic signed [WORD_W-1:0] intra_q_r, extra_q_r, iso_q_r;
  logic [1:0] sel_r;
  logic en_r;
  logic signed [WORD_W-1:0] w;
  logic signed [2*WORD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (wr_intra) intra_mem[wr_addr] <= wr_data;
    if (wr_extra) extra_mem[wr_addr] <= wr_data;
    if (wr_iso) iso_mem[wr_iso_addr] <= wr_data;
    intra_q_r <= intra_mem[rd_addr];
    extra_q_r <= extra_mem[rd_addr];
    iso_q_r <= iso_mem[rd_iso_addr];
    sel_r <= rd_sel;
    en_r <= en;
  end

  always_comb begin
    case (sel_r)
      2'd0: w = intra_q_r;
      2'd1: w = extra_q_r;
      default: w = iso_q_r;
    endcase
    prod = coef * w;
  end

  // arithmetic shift floors toward minus infinity
  always_ff @(posedge clk) begin
    term <= en_r ? TERM_W'(prod >>> 24) : '0;
  end

endmodule

FILE: rtl/ssmva_merge.sv
// sum lane terms and, for intra items, scale by segment length into the addend
module ssmva_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ssmva_pkg::lane_ctl_t                 ctl,
  input  logic signed [ssmva_pkg::TERM_W-1:0]  term0,
  input  logic signed [ssmva_pkg::TERM_W-1:0]  term1,
  input  logic signed [ssmva_pkg::TERM_W-1:0]  term2,
  input  logic signed [ssmva_pkg::TERM_W-1:0]  term3,
  input  logic [ssmva_pkg::LEN_W-1:0]          seg_len,
  output logic                                 add_valid,
  output logic signed [ssmva_pkg::ACC_W+1:0]   add_val
);
  import ssmva_pkg::*;

  // ctl arrives aligned with lane terms; the addend leaves two stages later
  logic [1:0] v_r;
  logic [1:0] intra_r;
  logic signed [DOT_W-1:0] dot_r;
  logic signed [DOT_W-24+LEN_W:0] hi_prod_r;
  logic [24+LEN_W-1:0] lo_prod_r;
  logic signed [DOT_W-1:0] dot2_r;

  // split the length product at bit 24: the high part carries the sign and the
  // low part is non-negative, so floor(dot*len/2^24) = hi*len + (lo*len >> 24)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[0], ctl.valid};
    end
    intra_r <= {intra_r[0], ctl.is_intra};
    dot_r <= DOT_W'(term0) + DOT_W'(term1) + DOT_W'(term2) + DOT_W'(term3);
    hi_prod_r <= $signed(dot_r[DOT_W-1:24]) * $signed({1'b0, seg_len});
    lo_prod_r <= dot_r[23:0] * seg_len;
    dot2_r <= dot_r;
  end

  logic signed [DOT_W+LEN_W-24:0] scaled;
  assign scaled = hi_prod_r + $signed({1'b0, lo_prod_r[24+LEN_W-1:24]});
  assign add_valid = v_r[1];
  assign add_val = intra_r[1] ? (ACC_W+2)'(scaled) : (ACC_W+2)'(dot2_r);

endmodule

FILE: rtl/structured_sparse_matvec_accumulate_unit.sv
// Structured sparse matrix-vector accumulator. Segment and voxel items
// (opcodes intra, extra, iso) sweep the first num_samples samples of their
// voxel at one sample per clock: up to four compartment lanes read their
// kernel memories and multiply in parallel, a merge stage sums and, for
// intra items, scales by segment length, and a saturating adder updates the
// accumulator memory. Table loads write on acceptance and reads return
// through the output hand-off; a clear walks the accumulator store one entry
// a cycle (VOXELS times the power of two at or above SAMPLES, 65536 entries
// by default, also run once after reset) before the next item is accepted.
// Kernel entries never written read as anything.
module structured_sparse_matvec_accumulate_unit
  import ssmva_pkg::*;
#(
  parameter int unsigned VOXELS = VOXELS_DEF,
  parameter int unsigned SAMPLES = SAMPLES_DEF,
  parameter int unsigned DIRECTIONS = DIRECTIONS_DEF,
  parameter int unsigned MAX_COMPARTMENTS = MAX_COMP_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,  // opcode
  // voxel, orientation, sample_index, compartment, seg_length,
  // coef_a, coef_b, coef_c, coef_d, table_value, then zero fill
  input  logic [223:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_voxel, out_sample, out_value, out_saturated, then zero fill
  output logic [71:0]  out_tdata
);
  localparam int unsigned SW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned DW = (DIRECTIONS > 1) ? $clog2(DIRECTIONS) : 1;
  localparam int unsigned VW = (VOXELS > 1) ? $clog2(VOXELS) : 1;
  localparam int unsigned AW = DW + SW;
  localparam int unsigned ACC_AW = VW + SW;
  localparam int unsigned ACC_DEPTH = VOXELS << SW;
  localparam int unsigned LIM = (MAX_COMPARTMENTS < 4) ? MAX_COMPARTMENTS : 4;
  localparam int unsigned LANE_N = LIM;

  // unpack input transaction
  logic [2:0] opc;
  logic [VOX_W-1:0] f_vox;
  logic [ORI_W-1:0] f_ori;
  logic [SMP_W-1:0] f_smp;
  logic [CMP_W-1:0] f_cmp;
  logic [LEN_W-1:0] f_len;
  logic signed [WORD_W-1:0] f_coef [4];
  logic signed [WORD_W-1:0] f_tv;
  assign opc = in_tuser;
  assign f_vox = in_tdata[9:0];
  assign f_ori = in_tdata[18:10];
  assign f_smp = in_tdata[24:19];
  assign f_cmp = in_tdata[26:25];
  assign f_len = in_tdata[57:27];
  assign f_coef[0] = in_tdata[89:58];
  assign f_coef[1] = in_tdata[121:90];
  assign f_coef[2] = in_tdata[153:122];
  assign f_coef[3] = in_tdata[185:154];
  assign f_tv = in_tdata[217:186];

  // configuration registers
  logic [2:0] num_radii_r, num_extra_r, num_iso_r;
  logic [6:0] num_samples_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_radii_r <= 3'd1;
      num_extra_r <= 3'd0;
      num_iso_r <= 3'd0;
      num_samples_r <= 7'd64;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_NUM_RADII: num_radii_r <= cfg_data[2:0];
        REG_NUM_EXTRA: num_extra_r <= cfg_data[2:0];
        REG_NUM_ISO: num_iso_r <= cfg_data[2:0];
        REG_NUM_SAMPLES: num_samples_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // item registers
  state_t state_r, state_nxt;
  logic [2:0] op_r;
  logic [VW-1:0] vox_r;
  logic [DW-1:0] ori_r;
  logic [SW-1:0] smp_r;
  logic [LEN_W-1:0] len_r;
  logic signed [WORD_W-1:0] coef_r [4];
  logic [3:0] lane_en_r;
  logic [8:0] cnt_r, ns_r;
  logic [3:0] drain_r;
  logic [ACC_AW:0] clr_r;
  logic rd_ok_r;
  logic sat_r;
  logic [VOX_W-1:0] rvox_r;
  logic [SMP_W-1:0] rsmp_r;
  logic [2:0] rd_pipe_r;
  logic out_v_r;
  logic signed [ACC_W-1:0] out_val_r;
  logic out_sat_r;
  logic acc_sat;

  logic accept, vox_ok, ori_ok, smp_ok, cmp_ok;
  logic [2:0] n_sel, n_eff;
  logic [8:0] ns_eff;
  assign accept = in_tvalid && in_tready;
  assign vox_ok = 32'(f_vox) < VOXELS;
  assign ori_ok = 32'(f_ori) < DIRECTIONS;
  assign smp_ok = 32'(f_smp) < SAMPLES;
  assign cmp_ok = 32'(f_cmp) < MAX_COMPARTMENTS;

  always_comb begin
    case (opcode_t'(opc))
      OP_INTRA: n_sel = num_radii_r;
      OP_EXTRA: n_sel = num_extra_r;
      default: n_sel = num_iso_r;
    endcase
    n_eff = (32'(n_sel) > LIM) ? 3'(LIM) : n_sel;
    ns_eff = (32'(num_samples_r) > SAMPLES) ? 9'(SAMPLES) : {2'b0, num_samples_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (opc == OP_CLEAR) state_nxt = ST_CLEAR;
          else if (opc == OP_READ) state_nxt = ST_READ;
          else if (opc <= OP_ISO && vox_ok && (opc == OP_ISO || ori_ok) && ns_eff != 0)
            state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: if (cnt_r == ns_r - 9'd1) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r == 4'd0) state_nxt = ST_IDLE;
      ST_READ: if (out_v_r && out_tready) state_nxt = ST_IDLE;
      ST_CLEAR: if (clr_r == (ACC_AW+1)'(ACC_DEPTH - 1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      cnt_r <= '0;
      drain_r <= '0;
      rd_pipe_r <= '0;
      out_v_r <= 1'b0;
      sat_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        clr_r <= '0;
        cnt_r <= '0;
        drain_r <= 4'd7;
        rd_pipe_r <= {2'b0, opc == OP_READ};
      end else begin
        if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
        if (state_r == ST_SWEEP) cnt_r <= cnt_r + 1'b1;
        if (state_r == ST_DRAIN) drain_r <= drain_r - 1'b1;
        rd_pipe_r <= {rd_pipe_r[1:0], 1'b0};
      end
      if (rd_pipe_r[2]) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      if (accept && opc == OP_CLEAR) sat_r <= 1'b0;
      else if (acc_sat) sat_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= opc;
      vox_r <= VW'(f_vox);
      ori_r <= DW'(f_ori);
      smp_r <= SW'(f_smp);
      len_r <= f_len;
      for (int k = 0; k < 4; k++) begin
        coef_r[k] <= f_coef[k];
        lane_en_r[k] <= (k < n_eff);
      end
      ns_r <= ns_eff;
      rvox_r <= f_vox;
      rsmp_r <= f_smp;
      rd_ok_r <= vox_ok && smp_ok;
    end
  end

  // lane array
  lane_ctl_t ctl;
  logic [SW-1:0] s_idx;
  logic signed [TERM_W-1:0] term [4];
  logic ld_ok;
  assign s_idx = SW'(cnt_r);
  assign ld_ok = accept && cmp_ok && smp_ok;
  assign ctl.valid = (state_r == ST_SWEEP);
  assign ctl.is_intra = (op_r == OP_INTRA);
  assign ctl.lane_en = lane_en_r;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    if (g < LANE_N) begin : g_on
      ssmva_lane #(
        .DEPTH(DIRECTIONS << SW), .ISO_DEPTH(SAMPLES), .AW(AW), .IAW(SW)
      ) u_lane (
        .clk(clk),
        .wr_intra(ld_ok && ori_ok && opc == OP_LD_INTRA && 32'(f_cmp) == g),
        .wr_extra(ld_ok && ori_ok && opc == OP_LD_EXTRA && 32'(f_cmp) == g),
        .wr_iso(ld_ok && opc == OP_LD_ISO && 32'(f_cmp) == g),
        .wr_addr({DW'(f_ori), SW'(f_smp)}),
        .wr_iso_addr(SW'(f_smp)),
        .wr_data(f_tv),
        .rd_addr({ori_r, s_idx}),
        .rd_iso_addr(s_idx),
        .rd_sel(op_r[1:0]),
        .en(ctl.lane_en[g] && ctl.valid),
        .coef(coef_r[g]),
        .term(term[g])
      );
    end else begin : g_off
      assign term[g] = '0;
    end
  end

  // ctl delayed to line up with lane terms (through the mem read and product registers)
  lane_ctl_t ctl_d1_r, ctl_d2_r;
  logic [SW-1:0] s_d [4];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d1_r <= '0;
      ctl_d2_r <= '0;
    end else begin
      ctl_d1_r <= ctl;
      ctl_d2_r <= ctl_d1_r;
    end
    s_d[0] <= s_idx;
    for (int i = 1; i < 4; i++) s_d[i] <= s_d[i-1];
  end

  logic add_valid;
  logic signed [ACC_W+1:0] add_val;
  ssmva_merge u_merge (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_d2_r),
    .term0(term[0]), .term1(term[1]), .term2(term[2]), .term3(term[3]),
    .seg_len(len_r), .add_valid(add_valid), .add_val(add_val)
  );

  // accumulator memory: read at add time, write saturated sum in the following cycle
  logic signed [ACC_W-1:0] acc_mem [ACC_DEPTH];
  logic signed [ACC_W-1:0] acc_q_r;
  logic [ACC_AW-1:0] rd_a, wa_r;
  logic wv_r;
  logic signed [ACC_W+1:0] addv_r;
  logic signed [ACC_W+1:0] sum;
  logic signed [ACC_W-1:0] sum_sat;

  always_comb begin
    if (state_r == ST_READ) rd_a = {vox_r, smp_r};
    else rd_a = {vox_r, s_d[3]};
    sum = (ACC_W+2)'(acc_q_r) + addv_r;
    acc_sat = wv_r && (sum > (ACC_W+2)'(ACC_MAX) || sum < (ACC_W+2)'(ACC_MIN));
    if (sum > (ACC_W+2)'(ACC_MAX)) sum_sat = ACC_MAX;
    else if (sum < (ACC_W+2)'(ACC_MIN)) sum_sat = ACC_MIN;
    else sum_sat = ACC_W'(sum);
  end

  always_ff @(posedge clk) begin
    acc_q_r <= acc_mem[rd_a];
    wa_r <= rd_a;
    addv_r <= add_val;
    if (!rst_n) wv_r <= 1'b0;
    else wv_r <= add_valid;
    if (state_r == ST_CLEAR) acc_mem[ACC_AW'(clr_r)] <= '0;
    else if (wv_r) acc_mem[wa_r] <= sum_sat;
    if (rd_pipe_r[2]) begin
      out_val_r <= rd_ok_r ? acc_q_r : '0;
      out_sat_r <= sat_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {7'b0, out_sat_r, out_val_r, rsmp_r, rvox_r};

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_v_r) else $error("accepting while a result waits");
  a_sat_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && opc == OP_CLEAR) |=> !sat_r) else $error("flag not cleared");
  a_write_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    wv_r |-> (state_r == ST_SWEEP || state_r == ST_DRAIN))
    else $error("accumulator write outside a sweep");

endmodule
